// ===== rtl/co2ul_pkg.sv =====
// Shared types, codes and frame helpers for the CO2 sensor UART link.
package co2ul_pkg;

    localparam int unsigned FRAME_LEN   = 9;
    localparam int unsigned POS_W       = $clog2(FRAME_LEN);
    localparam int unsigned TIMEOUT_W   = 16;
    localparam int unsigned TIME_W      = 32;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    localparam logic [7:0] FRAME_START  = 8'hFF;
    localparam logic [7:0] SENSOR_ADDR  = 8'h01;
    localparam logic [7:0] OP_READ      = 8'h86;
    localparam logic [7:0] OP_ABC       = 8'h79;
    localparam logic [7:0] OP_ZERO      = 8'h87;
    localparam logic [7:0] ABC_ON_CODE  = 8'hA0;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);

    typedef enum logic [2:0] {
        CMD_REQ_READ = 3'd0,
        CMD_SET_ABC  = 3'd1,
        CMD_ZERO_CAL = 3'd2,
        CMD_RX_BYTE  = 3'd3,
        CMD_TIME_UPD = 3'd4
    } co2ul_cmd_t;

    typedef enum logic [1:0] {
        KIND_TX_BYTE = 2'd0,
        KIND_READING = 2'd1,
        KIND_FAILED  = 2'd2,
        KIND_BUSY    = 2'd3
    } co2ul_kind_t;

    typedef enum logic {
        CAUSE_CHECKSUM = 1'b0,
        CAUSE_TIMEOUT  = 1'b1
    } co2ul_cause_t;

    typedef struct packed {
        logic [2:0]        command;
        logic              abc_on;
        logic [7:0]        rx_byte;
        logic [TIME_W-1:0] now_ms;
    } co2ul_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  tx_byte;
        logic        last_of_run;
        logic [15:0] co2_ppm;
        logic        fail_cause;
    } co2ul_out_t;

    // One pending result run: either a nine-byte frame or a single report.
    typedef struct packed {
        logic        is_frame;
        co2ul_kind_t kind;
        logic [7:0]  op_byte;
        logic [7:0]  b3;
        logic [15:0] ppm;
        logic        cause;
    } co2ul_desc_t;

    typedef struct packed {
        logic        valid;
        co2ul_desc_t desc;
    } co2ul_load_t;

    function automatic logic [7:0] frame_byte(input logic [7:0] op_byte,
                                              input logic [7:0] b3,
                                              input logic [POS_W-1:0] pos);
        logic [7:0] sum;
        logic [7:0] res;
        begin
            sum = SENSOR_ADDR + op_byte + b3;
            case (pos)
                POS_W'(0): res = FRAME_START;
                POS_W'(1): res = SENSOR_ADDR;
                POS_W'(2): res = op_byte;
                POS_W'(3): res = b3;
                LAST_POS:  res = 8'h00 - sum;
                default:   res = 8'h00;
            endcase
            return res;
        end
    endfunction

endpackage

// ===== rtl/co2ul_result_tx.sv =====
// Result stage: holds one result run and presents it beat by beat.
module co2ul_result_tx
    import co2ul_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  co2ul_load_t load,
    output logic        can_load,
    output logic        m_valid,
    input  logic        m_ready,
    output co2ul_out_t  m_payload
);

    logic              out_valid_reg, out_valid_next;
    co2ul_desc_t       desc_reg, desc_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              is_last;
    logic              take;

    assign is_last  = !desc_reg.is_frame || (pos_reg == LAST_POS);
    assign take     = out_valid_reg && m_ready;
    assign can_load = !out_valid_reg || (take && is_last);
    assign m_valid  = out_valid_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        desc_next      = desc_reg;
        pos_next       = pos_reg;
        if (take) begin
            if (is_last) begin
                out_valid_next = 1'b0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        if (load.valid && can_load) begin
            out_valid_next = 1'b1;
            desc_next      = load.desc;
            pos_next       = '0;
        end
    end

    always_comb begin
        m_payload = '0;
        if (desc_reg.is_frame) begin
            m_payload.result_kind = KIND_TX_BYTE;
            m_payload.tx_byte     = frame_byte(desc_reg.op_byte, desc_reg.b3, pos_reg);
            m_payload.last_of_run = (pos_reg == LAST_POS);
        end else begin
            m_payload.result_kind = desc_reg.kind;
            m_payload.last_of_run = 1'b1;
            m_payload.co2_ppm     = desc_reg.ppm;
            m_payload.fail_cause  = desc_reg.cause;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
        desc_reg <= desc_next;
    end

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (pos_reg <= LAST_POS))
        else $error("frame position ran past the checksum byte");

    a_single_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !desc_reg.is_frame) |-> (pos_reg == '0))
        else $error("single result advanced its position");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(pos_reg)))
        else $error("result run moved while the receiver stalled");

endmodule

// ===== rtl/co2_sensor_uart_link.sv =====
// Top level of the host side of a nine-byte CO2 sensor UART link.
//
// Usage:
//   s_valid/s_ready/s_payload carry one command beat: request read, set
//   auto-baseline, zero calibrate, received UART byte or time update.
//   m_valid/m_ready/m_payload carry result beats: the nine bytes of a
//   transmit frame (last_of_run on the checksum byte), or one report
//   (reading, failure with cause, or busy refusal) with last_of_run set.
//   cfg_we/cfg_wdata write the reply timeout in milliseconds; write only
//   while the link is idle.
// Ordering: a taken beat lands in the input register, is decoded once the
//   result stage has room, and its first result beat is then registered there.
// Throughput: one command beat per cycle when each yields at most one
//   result and m_ready holds high; a frame holds the result stage for
//   nine output beats, during which at most one further command is held in in_reg.
// Reset (aresetn low, synchronous): no reply is awaited, the parser sits
//   at the hunt position, timeout returns to 100 ms, both channels empty.
// Receiver stall: the pending result beat holds; the input register fills
//   and then s_ready drops until the result stage drains.
module co2_sensor_uart_link
    import co2ul_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [TIMEOUT_W-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  co2ul_in_t            s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output co2ul_out_t           m_payload
);

    // Input register
    logic      in_valid_reg, in_valid_next;
    co2ul_in_t in_reg, in_next;

    // Link state
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 waiting_reg, waiting_next;
    logic [3:0]           count_reg, count_next;
    logic [7:0]           sum_reg, sum_next;
    logic [15:0]          value_reg, value_next;
    logic [TIME_W-1:0]    deadline_reg, deadline_next;

    co2ul_load_t  load;
    logic         can_load;
    logic         advance;
    logic [TIME_W-1:0] since_deadline;
    logic [7:0]   expect_ck;

    // Decode one command once the result stage has room for its run.
    assign advance = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_next       = in_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_next       = s_payload;
        end
    end

    // Deadline is reached when now - deadline lies in the lower half range.
    assign since_deadline = in_reg.now_ms - deadline_reg;
    assign expect_ck      = 8'h00 - sum_reg;

    always_comb begin
        waiting_next  = waiting_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        value_next    = value_reg;
        deadline_next = deadline_reg;
        load          = '0;
        load.desc.kind = KIND_TX_BYTE;
        if (advance) begin
            case (co2ul_cmd_t'(in_reg.command))
                CMD_REQ_READ: begin
                    if (waiting_reg) begin
                        // refuse: a reply is still outstanding
                        load.valid     = 1'b1;
                        load.desc.kind = KIND_BUSY;
                    end else begin
                        count_next    = '0;
                        sum_next      = '0;
                        value_next    = '0;
                        waiting_next  = 1'b1;
                        deadline_next = in_reg.now_ms + TIME_W'(timeout_reg);
                        load.valid         = 1'b1;
                        load.desc.is_frame = 1'b1;
                        load.desc.op_byte  = OP_READ;
                    end
                end
                CMD_SET_ABC: begin
                    load.valid         = 1'b1;
                    load.desc.is_frame = 1'b1;
                    load.desc.op_byte  = OP_ABC;
                    load.desc.b3       = in_reg.abc_on ? ABC_ON_CODE : 8'h00;
                end
                CMD_ZERO_CAL: begin
                    load.valid         = 1'b1;
                    load.desc.is_frame = 1'b1;
                    load.desc.op_byte  = OP_ZERO;
                end
                CMD_RX_BYTE: begin
                    // drop bytes while no reply is awaited
                    if (waiting_reg) begin
                        if (count_reg == 4'd0) begin
                            // hunt for the start byte
                            if (in_reg.rx_byte == FRAME_START) begin
                                count_next = 4'd1;
                                sum_next   = '0;
                                value_next = '0;
                            end
                        end else if (count_reg == 4'd1 && in_reg.rx_byte != OP_READ) begin
                            // wrong echo; a repeated start byte keeps the hunt here
                            count_next = (in_reg.rx_byte == FRAME_START) ? 4'd1 : 4'd0;
                        end else if (count_reg < 4'd8) begin
                            sum_next   = sum_reg + in_reg.rx_byte;
                            count_next = count_reg + 4'd1;
                            if (count_reg == 4'd2) begin
                                value_next[15:8] = in_reg.rx_byte;
                            end else if (count_reg == 4'd3) begin
                                value_next[7:0] = in_reg.rx_byte;
                            end
                        end else begin
                            // checksum byte closes the reply
                            waiting_next = 1'b0;
                            count_next   = '0;
                            load.valid   = 1'b1;
                            if (expect_ck != in_reg.rx_byte) begin
                                load.desc.kind  = KIND_FAILED;
                                load.desc.cause = CAUSE_CHECKSUM;
                            end else begin
                                load.desc.kind = KIND_READING;
                                load.desc.ppm  = value_reg;
                            end
                        end
                    end
                end
                CMD_TIME_UPD: begin
                    if (waiting_reg && !since_deadline[TIME_W-1]) begin
                        waiting_next    = 1'b0;
                        count_next      = '0;
                        load.valid      = 1'b1;
                        load.desc.kind  = KIND_FAILED;
                        load.desc.cause = CAUSE_TIMEOUT;
                    end
                end
                default: begin
                    // unknown codes give no result
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
            waiting_reg  <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            value_reg    <= '0;
            deadline_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            waiting_reg  <= waiting_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            value_reg    <= value_next;
            deadline_reg <= deadline_next;
        end
        in_reg <= in_next;
    end

    co2ul_result_tx u_result_tx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_idle_parser_home: assert property (@(posedge aclk) disable iff (!aresetn)
        !waiting_reg |-> (count_reg == 4'd0))
        else $error("reply parser left its hunt position with no reply awaited");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 4'd8)
        else $error("reply byte count past the checksum position");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !can_load) |=> (in_valid_reg && $stable(in_reg)))
        else $error("waiting command beat lost or changed");

    a_load_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        load.valid |-> can_load)
        else $error("result run issued while the result stage was full");

endmodule

// ===== sim/co2_sensor_uart_link_test.sv =====
// Self-checking testbench for the CO2 sensor UART link: frames, reply parsing, timeouts.
module co2_sensor_uart_link_test;
    import co2ul_pkg::*;

    // Command codes past the last defined one are ignored by the link.
    localparam logic [2:0] CMD_CODE_MAX = 3'd7;
    // Give up after this many cycles in which neither channel moves a beat.
    localparam int STALL_LIMIT = 4000;
    // Random beats sent under each timeout setting.
    localparam int BEATS_PER_PHASE = 46;

    // Predict the result beats of each command beat and check them in order.
    class co2_link_board;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic                 awaiting;
        logic [3:0]           rx_pos;
        logic [7:0]           rx_sum;
        logic [15:0]          ppm_acc;
        logic [TIME_W-1:0]    deadline;
        co2ul_out_t           due_beats[$];
        int mismatches, checked, frames, readings, bad_sums, timeouts, refusals;

        function new();
            timeout_ms = TIMEOUT_RESET;
            awaiting   = 1'b0;
            rx_pos     = '0;
            rx_sum     = '0;
            ppm_acc    = '0;
            deadline   = '0;
            mismatches = 0;
            checked    = 0;
            frames     = 0;
            readings   = 0;
            bad_sums   = 0;
            timeouts   = 0;
            refusals   = 0;
        endfunction

        function void push_report(co2ul_kind_t kind, logic [15:0] ppm, co2ul_cause_t cause);
            co2ul_out_t r;
            r.result_kind = kind;
            r.tx_byte     = 8'h00;
            r.last_of_run = 1'b1;
            r.co2_ppm     = ppm;
            r.fail_cause  = cause;
            due_beats.push_back(r);
        endfunction

        // Queue the nine transmit bytes: FF 01 op b3 00 00 00 00 checksum.
        function void push_frame(logic [7:0] op, logic [7:0] b3);
            logic [7:0] bytes [0:8];
            logic [7:0] sum;
            co2ul_out_t r;
            bytes[0] = FRAME_START;
            bytes[1] = SENSOR_ADDR;
            bytes[2] = op;
            bytes[3] = b3;
            for (int i = 4; i < 8; i++) bytes[i] = 8'h00;
            sum = 8'h00;
            for (int i = 1; i < 8; i++) sum = sum + bytes[i];
            bytes[8] = 8'h00 - sum;
            for (int i = 0; i < 9; i++) begin
                r.result_kind = KIND_TX_BYTE;
                r.tx_byte     = bytes[i];
                r.last_of_run = (i == 8);
                r.co2_ppm     = 16'h0000;
                r.fail_cause  = CAUSE_CHECKSUM;
                due_beats.push_back(r);
            end
            frames++;
        endfunction

        function void take_command(co2ul_in_t it);
            logic [TIME_W-1:0] elapsed;
            case (it.command)
                CMD_REQ_READ: begin
                    if (awaiting) begin
                        push_report(KIND_BUSY, 16'h0000, CAUSE_CHECKSUM);
                        refusals++;
                    end else begin
                        rx_pos   = '0;
                        rx_sum   = '0;
                        ppm_acc  = '0;
                        awaiting = 1'b1;
                        deadline = it.now_ms + TIME_W'(timeout_ms);
                        push_frame(OP_READ, 8'h00);
                    end
                end
                CMD_SET_ABC:  push_frame(OP_ABC, it.abc_on ? ABC_ON_CODE : 8'h00);
                CMD_ZERO_CAL: push_frame(OP_ZERO, 8'h00);
                CMD_RX_BYTE: begin
                    if (!awaiting) begin
                        // drop bytes nobody asked for
                    end else if (rx_pos == 0) begin
                        if (it.rx_byte == FRAME_START) begin
                            rx_pos  = 4'd1;
                            rx_sum  = '0;
                            ppm_acc = '0;
                        end
                    end else if (rx_pos == 1 && it.rx_byte != OP_READ) begin
                        // a repeated start byte keeps the hunt one step in
                        rx_pos = (it.rx_byte == FRAME_START) ? 4'd1 : 4'd0;
                    end else if (rx_pos < 8) begin
                        rx_sum = rx_sum + it.rx_byte;
                        if (rx_pos == 2) ppm_acc[15:8] = it.rx_byte;
                        if (rx_pos == 3) ppm_acc[7:0] = it.rx_byte;
                        rx_pos = rx_pos + 4'd1;
                    end else begin
                        awaiting = 1'b0;
                        rx_pos   = '0;
                        if (8'h00 - rx_sum != it.rx_byte) begin
                            push_report(KIND_FAILED, 16'h0000, CAUSE_CHECKSUM);
                            bad_sums++;
                        end else begin
                            push_report(KIND_READING, ppm_acc, CAUSE_CHECKSUM);
                            readings++;
                        end
                    end
                end
                CMD_TIME_UPD: begin
                    elapsed = it.now_ms - deadline;
                    if (awaiting && !elapsed[TIME_W-1]) begin
                        awaiting = 1'b0;
                        rx_pos   = '0;
                        push_report(KIND_FAILED, 16'h0000, CAUSE_TIMEOUT);
                        timeouts++;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_beat(co2ul_out_t got);
            co2ul_out_t want;
            checked++;
            if (due_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result beat %0d arrived with nothing pending: ",
                              "kind %0d tx %h last %b ppm %h cause %b"},
                             checked, got.result_kind, got.tx_byte, got.last_of_run,
                             got.co2_ppm, got.fail_cause);
                return;
            end
            want = due_beats.pop_front();
            if (got.result_kind !== want.result_kind || got.tx_byte !== want.tx_byte ||
                got.last_of_run !== want.last_of_run || got.co2_ppm !== want.co2_ppm ||
                got.fail_cause !== want.fail_cause) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result beat %0d: expected kind %0d tx %h last %b ppm %h ",
                              "cause %b, got kind %0d tx %h last %b ppm %h cause %b"},
                             checked, want.result_kind, want.tx_byte, want.last_of_run,
                             want.co2_ppm, want.fail_cause, got.result_kind, got.tx_byte,
                             got.last_of_run, got.co2_ppm, got.fail_cause);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [TIMEOUT_W-1:0] cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    co2ul_in_t            s_payload;
    logic                 m_valid;
    logic                 m_ready;
    co2ul_out_t           m_payload;

    co2_link_board        board;
    logic [TIME_W-1:0]    ms_now;        // running sensor-side millisecond clock
    logic [TIMEOUT_W-1:0] cur_timeout;   // timeout the stimulus plans around
    bit                   quiet_stretch; // suppress all idling on both sides
    int                   beats_sent;
    int                   stall_cycles;

    co2_sensor_uart_link dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Receiver side: drop ready now and then, unless in the quiet stretch.
    always @(negedge aclk) begin
        m_ready <= quiet_stretch || ($urandom_range(99) >= 8);
    end

    // Check every result beat taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_beat(m_payload);
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results still pending",
                     STALL_LIMIT, board.due_beats.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one command beat at the falling edge, with random gaps ahead of it,
    // and hold it until the link takes it at a rising edge.
    task automatic send_beat(input co2ul_in_t it);
        @(negedge aclk);
        while (!quiet_stretch && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        board.take_command(it);
        beats_sent++;
    endtask

    task automatic send_cmd(input logic [2:0] code, input logic abc, input logic [7:0] rx,
                            input logic [TIME_W-1:0] now);
        co2ul_in_t it;
        it.command = code;
        it.abc_on  = abc;
        it.rx_byte = rx;
        it.now_ms  = now;
        send_beat(it);
    endtask

    // Feed a sensor reply: optional line noise, an optional doubled start byte,
    // then the first 'upto' bytes of the nine-byte frame.
    task automatic send_reply(input logic [15:0] ppm, input bit corrupt, input int upto);
        logic [7:0] frame_bytes [0:8];
        logic [7:0] sum;
        frame_bytes[0] = FRAME_START;
        frame_bytes[1] = OP_READ;
        frame_bytes[2] = ppm[15:8];
        frame_bytes[3] = ppm[7:0];
        for (int i = 4; i < 8; i++) frame_bytes[i] = 8'($urandom);
        sum = 8'h00;
        for (int i = 1; i < 8; i++) sum = sum + frame_bytes[i];
        frame_bytes[8] = 8'h00 - sum;
        if (corrupt) frame_bytes[8] = frame_bytes[8] ^ 8'($urandom_range(255, 1));
        repeat ($urandom_range(2))
            send_cmd(CMD_RX_BYTE, 1'($urandom_range(1)), 8'($urandom), $urandom);
        if ($urandom_range(3) == 0)
            send_cmd(CMD_RX_BYTE, 1'($urandom_range(1)), FRAME_START, $urandom);
        for (int i = 0; i < upto; i++)
            send_cmd(CMD_RX_BYTE, 1'($urandom_range(1)), frame_bytes[i], $urandom);
    endtask

    // One random exchange. Half are request/reply sequences, some with
    // cut-off replies; the rest are silent sensors, plain frames and stray beats.
    task automatic run_exchange();
        int                pick;
        int                upto;
        logic [15:0]       ppm;
        logic [TIME_W-1:0] due;
        pick = $urandom_range(99);
        due  = ms_now + TIME_W'(cur_timeout);
        if (pick < 50) begin
            send_cmd(CMD_REQ_READ, 1'($urandom_range(1)), 8'($urandom), ms_now);
            if ($urandom_range(3) == 0)
                send_cmd(CMD_TIME_UPD, 1'($urandom_range(1)), 8'($urandom),
                         due - 1 - $urandom_range(50));
            if ($urandom_range(4) == 0)
                send_cmd(CMD_REQ_READ, 1'($urandom_range(1)), 8'($urandom), $urandom);
            if ($urandom_range(5) == 0)
                send_cmd($urandom_range(1) ? CMD_SET_ABC : CMD_ZERO_CAL,
                         1'($urandom_range(1)), 8'($urandom), $urandom);
            case ($urandom_range(9))
                0:       ppm = 16'h0000;
                1:       ppm = 16'hFFFF;
                default: ppm = 16'($urandom);
            endcase
            upto = ($urandom_range(4) == 0) ? $urandom_range(8, 1) : 9;
            send_reply(ppm, $urandom_range(4) == 0, upto);
            if (upto < 9)
                send_cmd(CMD_TIME_UPD, 1'($urandom_range(1)), 8'($urandom),
                         due + $urandom_range(300));
        end else if (pick < 62) begin
            // sensor stays silent: one update short of the deadline, one at or past it
            send_cmd(CMD_REQ_READ, 1'($urandom_range(1)), 8'($urandom), ms_now);
            send_cmd(CMD_TIME_UPD, 1'($urandom_range(1)), 8'($urandom),
                     due - 1 - $urandom_range(1000));
            send_cmd(CMD_TIME_UPD, 1'($urandom_range(1)), 8'($urandom),
                     due + $urandom_range(300));
        end else if (pick < 76) begin
            send_cmd($urandom_range(1) ? CMD_SET_ABC : CMD_ZERO_CAL,
                     1'($urandom_range(1)), 8'($urandom), $urandom);
        end else if (pick < 86) begin
            // bytes with no reply awaited, including a valid-looking start
            send_cmd(CMD_RX_BYTE, 1'($urandom_range(1)), FRAME_START, $urandom);
            send_cmd(CMD_RX_BYTE, 1'($urandom_range(1)), OP_READ, $urandom);
            send_cmd(CMD_TIME_UPD, 1'($urandom_range(1)), 8'($urandom), $urandom);
        end else begin
            send_cmd(3'($urandom_range(CMD_CODE_MAX)), 1'($urandom_range(1)),
                     8'($urandom), $urandom);
        end
        ms_now = ms_now + TIME_W'($urandom_range(2000));
    endtask

    // Drain the link, give any result-free beat time to clear the input
    // register, then write the timeout.
    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.due_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        board.timeout_ms = value;
        cur_timeout      = value;
    endtask

    initial begin
        logic [TIMEOUT_W-1:0] settings [0:4];
        int                   phase_start;
        board         = new();
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_payload     = '0;
        m_ready       = 1'b0;
        quiet_stretch = 1'b0;
        beats_sent    = 0;
        stall_cycles  = 0;
        cur_timeout   = TIMEOUT_RESET;
        ms_now        = $urandom;
        settings[0]   = 16'd0;
        settings[1]   = 16'hFFFF;
        settings[2]   = 16'd1;
        settings[3]   = 16'($urandom_range(65534, 2));
        settings[4]   = TIMEOUT_RESET;

        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, under the reset timeout of 100 ms.
        // A byte with no reply pending is dropped; unknown codes give nothing.
        send_cmd(CMD_RX_BYTE, 1'b0, FRAME_START, 32'h0);
        for (int c = CMD_TIME_UPD + 1; c <= CMD_CODE_MAX; c++)
            send_cmd(3'(c), 1'b1, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(CMD_SET_ABC, 1'b1, 8'h00, 32'h0);
        send_cmd(CMD_SET_ABC, 1'b0, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(CMD_ZERO_CAL, 1'b0, 8'h00, 32'h0);
        // Request near the top of time so the deadline wraps to 0x54.
        send_cmd(CMD_REQ_READ, 1'b0, 8'h00, 32'hFFFF_FFF0);
        send_cmd(CMD_REQ_READ, 1'b1, 8'hFF, 32'h0);
        send_cmd(CMD_TIME_UPD, 1'b0, 8'h00, 32'h0000_0053);
        // Hunt: junk, start, repeated start, echo; a calibration slips in mid-reply.
        send_cmd(CMD_RX_BYTE, 1'b0, 8'h12, 32'h0);
        send_cmd(CMD_RX_BYTE, 1'b0, FRAME_START, 32'h0);
        send_cmd(CMD_RX_BYTE, 1'b0, FRAME_START, 32'h0);
        send_cmd(CMD_RX_BYTE, 1'b0, OP_READ, 32'h0);
        send_cmd(CMD_ZERO_CAL, 1'b1, 8'hFF, 32'hFFFF_FFFF);
        send_cmd(CMD_RX_BYTE, 1'b0, 8'hFF, 32'h0);
        send_cmd(CMD_RX_BYTE, 1'b0, 8'hFF, 32'h0);
        for (int i = 0; i < 4; i++) send_cmd(CMD_RX_BYTE, 1'b0, 8'h00, 32'h0);
        send_cmd(CMD_RX_BYTE, 1'b0, 8'h00 - (OP_READ + 8'hFF + 8'hFF), 32'h0);
        // Time update landing exactly on the deadline times out.
        send_cmd(CMD_REQ_READ, 1'b0, 8'h00, 32'h7FFF_FF00);
        send_cmd(CMD_TIME_UPD, 1'b0, 8'h00, 32'h7FFF_FF00 + TIME_W'(TIMEOUT_RESET));

        // Random part, one phase per timeout setting; the third runs without idling.
        for (int p = 0; p < 5; p++) begin
            write_timeout(settings[p]);
            quiet_stretch = (p == 2);
            phase_start   = beats_sent;
            while (beats_sent - phase_start < BEATS_PER_PHASE) run_exchange();
        end
        quiet_stretch = 1'b0;

        // Drain and let the tail settle.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.due_beats.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d command beats and %0d result beats over timeouts 0, 1, 100, %0d, 65535",
                 beats_sent, board.checked, settings[3]);
        $display({"predicted %0d frames, %0d readings, %0d checksum failures, ",
                  "%0d timeouts, %0d busy refusals"},
                 board.frames, board.readings, board.bad_sums, board.timeouts, board.refusals);
        if (board.mismatches == 0 && board.due_beats.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     board.mismatches, board.due_beats.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
